### design/tlsc_pkg.sv
// Shared types and constants for the tile light sphere culler.
`default_nettype none
package tlsc_pkg;

   localparam int TILE_LIST_DEPTH   = 64;
   localparam int SCENE_LIGHT_LIMIT = 1024;

   localparam int PLANE_COUNT  = 4;
   localparam int PLANE_IDX_W  = 2;
   localparam int NORMAL_W     = 16;
   localparam int COORD_W      = 32;
   localparam int RADIUS_W     = 31;
   localparam int PROD_W       = NORMAL_W + COORD_W;
   localparam int BIAS_W       = COORD_W + 2;
   localparam int FRAC_SHIFT   = 14;
   localparam int ACC_W        = 52;

   localparam int SLOT_W       = 6;
   localparam int VALUE_W      = 10;
   localparam int COUNT_W      = 7;

   localparam int REQ_TDATA_W  = 216;
   localparam int RSP_TDATA_W  = SLOT_W + VALUE_W;

   localparam int RSP_QUEUE_DEPTH = 4;
   localparam int QPTR_W          = 2;
   localparam int QCOUNT_W        = 3;

   localparam logic [VALUE_W-1:0] LIGHT_POS_WRAP = VALUE_W'(SCENE_LIGHT_LIMIT - 1);
   localparam logic [COUNT_W-1:0] LIST_FULL      = COUNT_W'(TILE_LIST_DEPTH);

   localparam logic FUNC_PLANE = 1'b0;
   localparam logic FUNC_LIGHT = 1'b1;

   localparam logic KIND_INDEX = 1'b0;
   localparam logic KIND_COUNT = 1'b1;

   typedef struct packed {
      logic signed [NORMAL_W-1:0] normal_x;
      logic signed [NORMAL_W-1:0] normal_y;
      logic signed [NORMAL_W-1:0] normal_z;
      logic signed [COORD_W-1:0]  plane_offset;
   } plane_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
      logic [RADIUS_W-1:0]       sphere_radius;
   } sphere_type;

   typedef struct packed {
      logic               kind;
      logic [SLOT_W-1:0]  slot;
      logic [VALUE_W-1:0] value;
      logic               done_res;
   } rsp_type;

endpackage
`default_nettype wire

### design/tlsc_plane_test.sv
// One side plane test: products, then exact Q.30 sum and sign check.
`default_nettype none
module tlsc_plane_test
   import tlsc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       advance,
   input  wire plane_type  plane,
   input  wire sphere_type sphere,
   output logic            pass_ff
);

   logic signed [PROD_W-1:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [PROD_W-1:0] prod_x_in, prod_y_in, prod_z_in;
   logic signed [BIAS_W-1:0] bias_ff, bias_in;
   logic signed [ACC_W-1:0]  acc;
   logic signed [PROD_W-1:0] bias_scaled;
   logic                     pass_in;

   assign prod_x_in = plane.normal_x * sphere.center_x;
   assign prod_y_in = plane.normal_y * sphere.center_y;
   assign prod_z_in = plane.normal_z * sphere.center_z;
   assign bias_in   = BIAS_W'(plane.plane_offset)
                    + BIAS_W'($signed({1'b0, sphere.sphere_radius}));

   // offset and radius move from Q16.16 to Q.30
   assign bias_scaled = $signed({bias_ff, {FRAC_SHIFT{1'b0}}});
   assign acc = ACC_W'(prod_x_ff) + ACC_W'(prod_y_ff) + ACC_W'(prod_z_ff)
              + ACC_W'(bias_scaled);
   assign pass_in = ~acc[ACC_W-1];

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
         bias_ff   <= bias_in;
         pass_ff   <= pass_in;
      end
   end

endmodule
`default_nettype wire

### design/tlsc_rsp_fifo.sv
// Small result queue: up to two writes and one read per cycle.
`default_nettype none
module tlsc_rsp_fifo
   import tlsc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push_a,
   input  wire rsp_type        data_a,
   input  wire logic           push_b,
   input  wire rsp_type        data_b,
   input  wire logic           pop,
   output logic                head_valid,
   output rsp_type             head,
   output logic [QCOUNT_W-1:0] count_ff
);

   rsp_type             entry_ff [RSP_QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_in;
   logic [QPTR_W-1:0]   wr_next;
   logic [QCOUNT_W-1:0] n_push;

   assign wr_next    = wr_ptr_ff + QPTR_W'(1);
   assign n_push     = QCOUNT_W'(push_a) + QCOUNT_W'(push_b);
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign wr_ptr_in  = wr_ptr_ff + QPTR_W'(n_push);
   assign rd_ptr_in  = rd_ptr_ff + QPTR_W'(pop);
   assign count_in   = count_ff + n_push - QCOUNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_a) begin
         entry_ff[wr_ptr_ff] <= data_a;
      end
      if (push_b) begin
         entry_ff[wr_next] <= data_b;
      end
   end

endmodule
`default_nettype wire

### design/tile_light_sphere_culler_core.sv
// Top level of the tile light sphere culler.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/tready    | tdata: planes, sphere; tuser func; tlast last
//  rsp     | out       | rsp_tvalid/tready    | tdata: slot, value; tuser kind; tlast done
//
// One transaction enters per cycle while req_tready is high. A light's results pass the input
// register, product register and plane test register before they reach the queue.
// A light that gives two results writes both of them into the queue together.
// req_tready drops only while the four-entry result queue holds three or more results.
// Reset clears the pipeline valids, the queue and both counters; planes must be loaded.
`default_nettype none
module tile_light_sphere_culler_core
   import tlsc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // plane_slot[1:0], normal_x[17:2], normal_y[33:18], normal_z[49:34],
   // plane_offset[81:50], center_x[113:82], center_y[145:114], center_z[177:146],
   // sphere_radius[208:178], zero fill [215:209]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // func
   input  wire logic                   req_tuser,
   input  wire logic                   req_tlast,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // slot[5:0], value[15:6]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // kind
   output logic                        rsp_tuser,
   output logic                        rsp_tlast
);

   logic                   advance;
   logic [QCOUNT_W-1:0]    q_count;

   logic                   s1_valid_ff;
   logic                   s1_func_ff;
   logic [PLANE_IDX_W-1:0] s1_slot_ff;
   plane_type              s1_plane_ff;
   sphere_type             s1_sphere_ff;
   logic                   s1_last_ff;

   plane_type              plane_store_ff [PLANE_COUNT];

   logic                   s2_valid_ff, s2_valid_in;
   logic                   s2_last_ff;
   logic                   s3_valid_ff;
   logic                   s3_last_ff;
   logic [PLANE_COUNT-1:0] pass_vec;

   logic [COUNT_W-1:0]     kept_count_ff, kept_count_in, count_new;
   logic [VALUE_W-1:0]     light_pos_ff, light_pos_in;
   logic                   emit_idx;
   rsp_type                idx_rsp, cnt_rsp, data_a;
   logic                   push_a, push_b;
   logic                   head_valid, pop;
   rsp_type                head;

   assign advance    = (q_count <= QCOUNT_W'(RSP_QUEUE_DEPTH - 2));
   assign req_tready = advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_func_ff                 <= req_tuser;
         s1_last_ff                 <= req_tlast;
         s1_slot_ff                 <= req_tdata[1:0];
         s1_plane_ff.normal_x       <= req_tdata[17:2];
         s1_plane_ff.normal_y       <= req_tdata[33:18];
         s1_plane_ff.normal_z       <= req_tdata[49:34];
         s1_plane_ff.plane_offset   <= req_tdata[81:50];
         s1_sphere_ff.center_x      <= req_tdata[113:82];
         s1_sphere_ff.center_y      <= req_tdata[145:114];
         s1_sphere_ff.center_z      <= req_tdata[177:146];
         s1_sphere_ff.sphere_radius <= req_tdata[208:178];
      end
   end

   // plane loads take effect as they leave the input register, ahead of later lights
   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff && s1_func_ff == FUNC_PLANE) begin
         plane_store_ff[s1_slot_ff] <= s1_plane_ff;
      end
   end

   genvar p;
   generate
      for (p = 0; p < PLANE_COUNT; p++) begin : g_plane
         tlsc_plane_test u_plane_test (
            .clock   (clock),
            .advance (advance),
            .plane   (plane_store_ff[p]),
            .sphere  (s1_sphere_ff),
            .pass_ff (pass_vec[p])
         );
      end
   endgenerate

   assign s2_valid_in = s1_valid_ff && (s1_func_ff == FUNC_LIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_last_ff <= s1_last_ff;
         s3_last_ff <= s2_last_ff;
      end
   end

   // tile list bookkeeping
   assign emit_idx  = s3_valid_ff && (&pass_vec) && (kept_count_ff < LIST_FULL);
   assign count_new = emit_idx ? kept_count_ff + COUNT_W'(1) : kept_count_ff;

   always_comb begin
      kept_count_in = kept_count_ff;
      light_pos_in  = light_pos_ff;
      if (s3_valid_ff) begin
         kept_count_in = count_new;
         light_pos_in  = (light_pos_ff == LIGHT_POS_WRAP) ? '0
                                                          : light_pos_ff + VALUE_W'(1);
         if (s3_last_ff) begin
            kept_count_in = '0;
            light_pos_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_count_ff <= '0;
         light_pos_ff  <= '0;
      end else if (advance) begin
         kept_count_ff <= kept_count_in;
         light_pos_ff  <= light_pos_in;
      end
   end

   always_comb begin
      idx_rsp.kind     = KIND_INDEX;
      idx_rsp.slot     = kept_count_ff[SLOT_W-1:0];
      idx_rsp.value    = light_pos_ff;
      idx_rsp.done_res = 1'b0;
      cnt_rsp.kind     = KIND_COUNT;
      cnt_rsp.slot     = '0;
      cnt_rsp.value    = VALUE_W'(count_new);
      cnt_rsp.done_res = 1'b1;
   end

   // index result goes first when a closing light is also kept
   assign push_a = advance && s3_valid_ff && (emit_idx || s3_last_ff);
   assign push_b = advance && s3_valid_ff && emit_idx && s3_last_ff;
   assign data_a = emit_idx ? idx_rsp : cnt_rsp;

   assign pop = head_valid && rsp_tready;

   tlsc_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_a     (push_a),
      .data_a     (data_a),
      .push_b     (push_b),
      .data_b     (cnt_rsp),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head),
      .count_ff   (q_count)
   );

   assign rsp_tvalid = head_valid;
   assign rsp_tdata  = {head.value, head.slot};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.done_res;

endmodule
`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the tile light sphere culler: directed table, then random tiles.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tlsc_pkg::*;

   localparam logic [1:0]  SLOT_LEFT   = 2'd0;
   localparam logic [1:0]  SLOT_RIGHT  = 2'd1;
   localparam logic [1:0]  SLOT_TOP    = 2'd2;
   localparam logic [1:0]  SLOT_BOTTOM = 2'd3;
   localparam logic [15:0] ONE_Q14     = 16'h4000;
   localparam logic [15:0] NEG_ONE_Q14 = 16'hC000;
   localparam logic [31:0] COORD_MIN   = 32'h8000_0000;
   localparam logic [31:0] COORD_MAX   = 32'h7FFF_FFFF;
   localparam logic [30:0] RADIUS_MAX  = 31'h7FFF_FFFF;
   localparam int RANDOM_ITEMS   = 1350;
   localparam int TAIL_ITEMS     = 150;
   localparam int LONG_TILE      = 1040;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 16;

   typedef struct {
      logic       func;
      logic [1:0] sel;
      plane_type  pl;
      sphere_type sp;
      logic       lst;
      int         n_typed;   // -1: take the results from the culling predictor
      rsp_type    e0;
      rsp_type    e1;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;

   // culling state mirrored from the block
   plane_type          plane_store [PLANE_COUNT];
   logic [COUNT_W-1:0] kept_total = '0;
   logic [VALUE_W-1:0] light_number = '0;
   rsp_type            awaited_results [$];
   stim_row_type       directed_rows [$];

   int mismatches = 0;
   int items_accepted = 0;
   int stop_at = 0;
   int send_odds = 4;
   int take_odds = 4;
   int hold_at = 0;
   int hold_left = 0;
   int stall_left = 0;
   int quiet_cycles = 0;
   bit hold_done = 1'b0;
   bit tail_phase = 1'b0;

   always #2 clock = ~clock;

   tile_light_sphere_culler_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   function automatic plane_type face(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                                      logic [31:0] off);
      return '{normal_x: nx, normal_y: ny, normal_z: nz, plane_offset: off};
   endfunction

   function automatic sphere_type ball(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                       logic [30:0] r);
      return '{center_x: cx, center_y: cy, center_z: cz, sphere_radius: r};
   endfunction

   function automatic rsp_type index_rsp(logic [SLOT_W-1:0] s, logic [VALUE_W-1:0] v);
      return '{kind: KIND_INDEX, slot: s, value: v, done_res: 1'b0};
   endfunction

   function automatic rsp_type count_rsp(logic [VALUE_W-1:0] v);
      return '{kind: KIND_COUNT, slot: '0, value: v, done_res: 1'b1};
   endfunction

   function automatic stim_row_type plane_row(logic [1:0] sel, plane_type pl, logic lst);
      stim_row_type row;
      row.func = FUNC_PLANE;
      row.sel = sel;
      row.pl = pl;
      row.sp = ball('0, '0, '0, '0);
      row.lst = lst;
      row.n_typed = 0;
      row.e0 = count_rsp('0);
      row.e1 = count_rsp('0);
      return row;
   endfunction

   function automatic stim_row_type light_row(sphere_type sp, logic lst, int n, rsp_type e0,
                                              rsp_type e1);
      stim_row_type row;
      row.func = FUNC_LIGHT;
      row.sel = '0;
      row.pl = face('0, '0, '0, '0);
      row.sp = sp;
      row.lst = lst;
      row.n_typed = n;
      row.e0 = e0;
      row.e1 = e1;
      return row;
   endfunction

   function automatic plane_type box_face(logic [1:0] side, logic [31:0] w);
      case (side)
         SLOT_LEFT:  return face(ONE_Q14, '0, '0, w);
         SLOT_RIGHT: return face(NEG_ONE_Q14, '0, '0, w);
         SLOT_TOP:   return face('0, ONE_Q14, '0, w);
         default:    return face('0, NEG_ONE_Q14, '0, w);
      endcase
   endfunction

   // exact test in Q.30: every plane needs n.c + offset + radius >= 0
   function automatic bit sphere_inside(sphere_type s);
      longint acc;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         acc = longint'($signed(plane_store[p].normal_x)) * longint'($signed(s.center_x))
             + longint'($signed(plane_store[p].normal_y)) * longint'($signed(s.center_y))
             + longint'($signed(plane_store[p].normal_z)) * longint'($signed(s.center_z));
         acc += longint'($signed(plane_store[p].plane_offset)) * 64'sd16384;
         acc += longint'({1'b0, s.sphere_radius}) * 64'sd16384;
         if (acc < 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void cull_light(sphere_type sp, logic lst, output int n,
                                      output rsp_type r0, output rsp_type r1);
      rsp_type tally;
      n = 0;
      r0 = count_rsp('0);
      r1 = count_rsp('0);
      if (sphere_inside(sp) && kept_total < TILE_LIST_DEPTH) begin
         r0 = index_rsp(kept_total[SLOT_W-1:0], light_number);
         n = 1;
         kept_total = kept_total + 1'b1;
      end
      light_number = (light_number == LIGHT_POS_WRAP) ? '0 : light_number + 1'b1;
      if (lst) begin
         tally = count_rsp(VALUE_W'(kept_total));
         if (n == 0) r0 = tally;
         else r1 = tally;
         n++;
         kept_total = '0;
         light_number = '0;
      end
   endfunction

   function automatic logic [15:0] rand_normal();
      case ($urandom_range(0, 7))
         0: return ONE_Q14;
         1: return NEG_ONE_Q14;
         2: return 16'($urandom());
         3: return '0;
         default: return 16'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 7))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return '0;
         3, 4: return 32'($urandom_range(0, 131072) - 65536);
         5: return 32'($urandom_range(0, 1 << 25) - (1 << 24));
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [30:0] rand_radius();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return RADIUS_MAX;
         2: return 31'($urandom_range(0, 1 << 17));
         3, 4: return 31'($urandom_range(0, 1 << 26));
         default: return 31'($urandom());
      endcase
   endfunction

   // steer towards the wanted outcome; give up quietly after a few tries
   function automatic sphere_type pick_sphere(bit want_kept);
      sphere_type s;
      for (int t = 0; t < 12; t++) begin
         s = ball(rand_coord(), rand_coord(), rand_coord(), rand_radius());
         if (sphere_inside(s) == want_kept) break;
      end
      return s;
   endfunction

   task automatic log_mismatch(string what, int got, int want);
      if (mismatches < 50)
         $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic check_result(rsp_type got);
      rsp_type want;
      if (awaited_results.size() == 0) begin
         log_mismatch("result with nothing awaited, value", got.value, 0);
         return;
      end
      want = awaited_results.pop_front();
      if (got.kind !== want.kind) log_mismatch("kind", got.kind, want.kind);
      if (got.slot !== want.slot) log_mismatch("slot", got.slot, want.slot);
      if (got.value !== want.value) log_mismatch("value", got.value, want.value);
      if (got.done_res !== want.done_res) log_mismatch("done", got.done_res, want.done_res);
   endtask

   task automatic drive_item(stim_row_type row);
      logic [81:0]  plane_bits;
      logic [126:0] sphere_bits;
      int           n;
      rsp_type      r0, r1;
      tail_phase = items_accepted >= stop_at - TAIL_ITEMS;
      if (!tail_phase && send_odds != 0 && $urandom_range(1, send_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      plane_bits = {row.pl.plane_offset, row.pl.normal_z, row.pl.normal_y, row.pl.normal_x,
                    row.sel};
      sphere_bits = {row.sp.sphere_radius, row.sp.center_z, row.sp.center_y, row.sp.center_x};
      // fill the fields the block ignores with noise
      if (row.func == FUNC_LIGHT) plane_bits = 82'({$urandom(), $urandom(), $urandom()});
      else sphere_bits = 127'({$urandom(), $urandom(), $urandom(), $urandom()});
      req_tvalid <= 1'b1;
      req_tuser <= row.func;
      req_tlast <= row.lst;
      req_tdata <= {7'd0, sphere_bits, plane_bits};
      do @(posedge clock); while (req_tready !== 1'b1);
      items_accepted++;
      n = 0;
      r0 = count_rsp('0);
      r1 = count_rsp('0);
      if (row.func == FUNC_PLANE) plane_store[row.sel] = row.pl;
      else cull_light(row.sp, row.lst, n, r0, r1);
      if (row.n_typed >= 0) begin
         n = row.n_typed;
         r0 = row.e0;
         r1 = row.e1;
      end
      if (n > 0) awaited_results.push_back(r0);
      if (n > 1) awaited_results.push_back(r1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaited_results.size() != 0);
   endtask

   task automatic build_directed();
      rsp_type none;
      none = count_rsp('0);
      // box planes with zero offset: kept when |cx| <= r and |cy| <= r
      directed_rows.push_back(plane_row(SLOT_LEFT, box_face(SLOT_LEFT, '0), 1'b0));
      directed_rows.push_back(plane_row(SLOT_RIGHT, box_face(SLOT_RIGHT, '0), 1'b1));
      directed_rows.push_back(plane_row(SLOT_TOP, box_face(SLOT_TOP, '0), 1'b0));
      directed_rows.push_back(plane_row(SLOT_BOTTOM, box_face(SLOT_BOTTOM, '0), 1'b0));
      directed_rows.push_back(light_row(ball('0, '0, '0, '0), 1'b0, 1,
                                        index_rsp(6'd0, 10'd0), none));
      directed_rows.push_back(light_row(ball(32'd1, '0, '0, '0), 1'b0, 0, none, none));
      directed_rows.push_back(light_row(ball(32'hFFFF_FFFF, '0, '0, 31'd1), 1'b0, 1,
                                        index_rsp(6'd1, 10'd2), none));
      directed_rows.push_back(light_row(ball(COORD_MAX, '0, '0, RADIUS_MAX), 1'b0, 1,
                                        index_rsp(6'd2, 10'd3), none));
      directed_rows.push_back(light_row(ball(COORD_MIN, '0, '0, RADIUS_MAX), 1'b0, 0,
                                        none, none));
      directed_rows.push_back(light_row(ball('0, COORD_MAX, COORD_MIN, RADIUS_MAX), 1'b0, 1,
                                        index_rsp(6'd3, 10'd5), none));
      // last light rejected, then a one-light tile, then a tile whose only light is rejected
      directed_rows.push_back(light_row(ball('0, 32'd5, '0, '0), 1'b1, 1,
                                        count_rsp(10'd4), none));
      directed_rows.push_back(light_row(ball('0, '0, '0, '0), 1'b1, 2,
                                        index_rsp(6'd0, 10'd0), count_rsp(10'd1)));
      directed_rows.push_back(light_row(ball(32'd7, 32'd7, COORD_MAX, '0), 1'b1, 1,
                                        count_rsp(10'd0), none));
      // normals outside the stated range and extreme offsets
      directed_rows.push_back(plane_row(SLOT_BOTTOM,
                                        face(16'h8000, 16'h7FFF, NEG_ONE_Q14, COORD_MIN), 1'b1));
      directed_rows.push_back(plane_row(SLOT_TOP,
                                        face(ONE_Q14, ONE_Q14, ONE_Q14, COORD_MAX), 1'b0));
      directed_rows.push_back(light_row(ball(COORD_MIN, COORD_MIN, COORD_MIN, RADIUS_MAX),
                                        1'b0, -1, none, none));
      directed_rows.push_back(light_row(ball(COORD_MAX, COORD_MAX, COORD_MAX, '0),
                                        1'b0, -1, none, none));
      directed_rows.push_back(light_row(ball(COORD_MIN, COORD_MAX, '0, RADIUS_MAX),
                                        1'b0, -1, none, none));
      directed_rows.push_back(light_row(ball('0, '0, '0, RADIUS_MAX), 1'b1, -1, none, none));
      directed_rows.push_back(plane_row(SLOT_TOP, box_face(SLOT_TOP, '0), 1'b0));
      directed_rows.push_back(plane_row(SLOT_BOTTOM, box_face(SLOT_BOTTOM, '0), 1'b0));
   endtask

   task automatic load_planes(int first, int count, bit boxed, logic [31:0] w, bit rand_last);
      logic [1:0] side;
      plane_type  pl;
      for (int i = 0; i < count; i++) begin
         side = 2'(first + i);
         pl = boxed ? box_face(side, w)
                    : face(rand_normal(), rand_normal(), rand_normal(), rand_coord());
         drive_item(plane_row(side, pl, rand_last ? 1'($urandom()) : 1'b0));
      end
   endtask

   task automatic run_random();
      int  tile_len;
      int  keep_pct;
      bit  long_done;
      bit  paused;
      bit  want;
      long_done = 1'b0;
      paused = 1'b0;
      while (items_accepted < stop_at) begin
         case ($urandom_range(0, 2))
            0: send_odds = 0;
            1: send_odds = 3;
            default: send_odds = 8;
         endcase
         if (!paused && items_accepted > 600) begin
            paused = 1'b1;
            wait_drained();
         end
         if (!long_done && items_accepted > 220) begin
            // one long tile of mostly rejected lights, long enough to wrap the light numbering
            long_done = 1'b1;
            load_planes(0, PLANE_COUNT, 1'b1, 32'($urandom_range(1 << 16, 1 << 24)), 1'b0);
            for (int i = 0; i < LONG_TILE; i++) begin
               want = (i >= LONG_TILE - 24) ? 1'($urandom()) : ($urandom_range(0, 99) < 4);
               drive_item(light_row(pick_sphere(want), i == LONG_TILE - 1, -1,
                                    count_rsp('0), count_rsp('0)));
            end
            continue;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               load_planes($urandom_range(0, 3), PLANE_COUNT, 1'($urandom()),
                           32'($urandom_range(0, 1 << 22)), 1'b1);
               if ($urandom_range(0, 5) == 0) begin
                  tile_len = $urandom_range(60, 80);
                  keep_pct = 95;
               end else begin
                  tile_len = $urandom_range(1, 20);
                  keep_pct = $urandom_range(0, 100);
               end
               for (int i = 0; i < tile_len; i++)
                  drive_item(light_row(pick_sphere($urandom_range(0, 99) < keep_pct),
                                       i == tile_len - 1, -1, count_rsp('0), count_rsp('0)));
            end
            6, 7: begin
               // partial reload in the middle of a tile
               load_planes($urandom_range(0, 3), $urandom_range(1, 2), 1'($urandom()),
                           32'($urandom_range(0, 1 << 22)), 1'b1);
               tile_len = $urandom_range(1, 8);
               for (int i = 0; i < tile_len; i++)
                  drive_item(light_row(pick_sphere(1'($urandom())), 1'($urandom()), -1,
                                       count_rsp('0), count_rsp('0)));
            end
            default: begin
               tile_len = $urandom_range(1, 4);
               for (int i = 0; i < tile_len; i++)
                  drive_item(light_row(ball(rand_coord(), rand_coord(), rand_coord(),
                                            rand_radius()), 1'($urandom()), -1,
                                       count_rsp('0), count_rsp('0)));
            end
         endcase
      end
   endtask

   // result side: check, then decide readiness for the next edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_result('{kind: rsp_tuser, slot: rsp_tdata[SLOT_W-1:0],
                        value: rsp_tdata[RSP_TDATA_W-1:SLOT_W], done_res: rsp_tlast});
      if ($urandom_range(0, 63) == 0) begin
         case ($urandom_range(0, 2))
            0: take_odds = 0;
            1: take_odds = 3;
            default: take_odds = 8;
         endcase
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && hold_at != 0 && items_accepted >= hold_at) begin
         // hold off long enough for the result queue to fill and stall the input
         hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!tail_phase && take_odds != 0 && $urandom_range(1, take_odds) == 1) begin
         stall_left = $urandom_range(0, 9);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      build_directed();
      stop_at = directed_rows.size() + RANDOM_ITEMS;
      hold_at = directed_rows.size() + 40;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) drive_item(directed_rows[i]);
      wait_drained();
      run_random();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
`default_nettype wire

### files.f
design/tlsc_pkg.sv
design/tlsc_plane_test.sv
design/tlsc_rsp_fifo.sv
design/tile_light_sphere_culler_core.sv
verif/tb.sv
